[design/tbf_pkg.sv]
// Package with shared types and constants for the timed brightness fade block.
package tbf_pkg;

  // Operation codes carried by a request.
  typedef enum logic [1:0] {
    OP_FADE = 2'd0,
    OP_TICK = 2'd1,
    OP_SYNC = 2'd2
  } op_t;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_LOAD,
    ST_DIV_WAIT
  } state_t;

  // Fixed widths of the ramp arithmetic.
  localparam int LEVEL_W = 8;
  localparam int LEN_W   = 16;
  localparam int TIME_W  = 32;
  localparam int PROD_W  = LEVEL_W + LEN_W;
  localparam int CNT_W   = $clog2(PROD_W + 1);

endpackage

[design/timed_brightness_fade.sv]
// Top level of the time-based linear brightness fade.
//
//   Channel  Signals                                      Direction
//   in       in_valid, in_stall, op, target_level,        request in
//            duration_ms, now_ms
//   out      out_valid, out_stall, level, done_res,       result out
//            level_written
//
// Fade, sync, unused codes and ticks needing no ramp step load the result at the accept edge.
// A mid-fade tick loads it after one multiply, one divider load, the 24 steps of the
// bit-serial divider and the result load.
// Reset (rst, synchronous) clears the start, goal and current levels, the start time and the fade length to zero.
// One request is in work at a time; in_stall is high while the sequencer is busy or a
// result waits on a stalled output.
module timed_brightness_fade
  import tbf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         op,
  input  logic [LEVEL_W-1:0] target_level,
  input  logic [LEN_W-1:0]   duration_ms,
  input  logic [TIME_W-1:0]  now_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [LEVEL_W-1:0] level,
  output logic               done_res,
  output logic               level_written
);

  state_t             state, state_next;
  logic [LEVEL_W-1:0] start_level, start_level_next;
  logic [LEVEL_W-1:0] goal_level, goal_level_next;
  logic [LEVEL_W-1:0] now_level, now_level_next;
  logic [TIME_W-1:0]  start_time, start_time_next;
  logic [LEN_W-1:0]   fade_length, fade_length_next;
  logic [LEN_W-1:0]   elapsed_lo, elapsed_lo_next;
  logic [PROD_W-1:0]  product;
  logic [PROD_W-1:0]  quotient;
  logic               out_load;
  logic               wrote;
  logic               accept;
  logic               need_ramp;
  logic               ramp_up;
  logic [LEVEL_W-1:0] span;
  logic [TIME_W-1:0]  elapsed;
  logic [LEVEL_W-1:0] ramp_level;
  logic               div_start;
  logic               div_done;

  assign in_stall = (state != ST_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  // Ramp direction, span and elapsed time.
  assign ramp_up = goal_level >= start_level;
  assign span    = ramp_up ? goal_level - start_level : start_level - goal_level;
  assign elapsed = now_ms - start_time;
  assign need_ramp = (op == OP_TICK) && (now_level != goal_level) &&
                     (fade_length != '0) && (elapsed < {{(TIME_W-LEN_W){1'b0}}, fade_length});
  assign ramp_level = ramp_up ? start_level + quotient[LEVEL_W-1:0]
                              : start_level - quotient[LEVEL_W-1:0];

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && need_ramp) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL:      state_next = ST_DIV_LOAD;
      ST_DIV_LOAD: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_next = ST_IDLE;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  // Datapath updates and result loading per state.
  always_comb begin
    start_level_next = start_level;
    goal_level_next  = goal_level;
    now_level_next   = now_level;
    start_time_next  = start_time;
    fade_length_next = fade_length;
    elapsed_lo_next  = elapsed_lo;
    out_load         = 1'b0;
    wrote            = 1'b0;
    div_start        = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          out_load = 1'b1;
          case (op)
            OP_FADE: begin
              if (target_level != goal_level) begin
                start_level_next = now_level;
                goal_level_next  = target_level;
                start_time_next  = now_ms;
                fade_length_next = duration_ms;
                if (duration_ms == '0) begin
                  now_level_next = target_level;
                  wrote          = 1'b1;
                end
              end
            end
            OP_TICK: begin
              if (need_ramp) begin
                elapsed_lo_next = elapsed[LEN_W-1:0];
                out_load        = 1'b0;
              end else if (now_level != goal_level) begin
                now_level_next = goal_level;
                wrote          = 1'b1;
              end
            end
            OP_SYNC: begin
              start_level_next = target_level;
              goal_level_next  = target_level;
              now_level_next   = target_level;
              wrote            = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_DIV_LOAD: div_start = 1'b1;
      ST_DIV_WAIT: begin
        if (div_done) begin
          now_level_next = ramp_level;
          wrote          = 1'b1;
          out_load       = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control and fade state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      start_level <= '0;
      goal_level  <= '0;
      now_level   <= '0;
      start_time  <= '0;
      fade_length <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      start_level <= start_level_next;
      goal_level  <= goal_level_next;
      now_level   <= now_level_next;
      start_time  <= start_time_next;
      fade_length <= fade_length_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: product of span and elapsed time, and the result.
  always_ff @(posedge clk) begin
    elapsed_lo <= elapsed_lo_next;
    if (state == ST_MUL) begin
      product <= PROD_W'(span) * PROD_W'(elapsed_lo);
    end
    if (out_load) begin
      level         <= now_level_next;
      done_res      <= now_level_next == goal_level_next;
      level_written <= wrote;
    end
  end

  // Divider for the ramp quotient.
  tbf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .divisor  (fade_length),
    .done     (div_done),
    .quotient (quotient)
  );

  // The output register is empty for the whole division.
  a_out_free_in_div: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV_WAIT) |-> !out_valid)
    else $error("result pending while a ramp division runs");

  // The divider finishes only while the sequencer waits for it.
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV_WAIT))
    else $error("divider finished outside its wait state");

  // A sync request always reports a written level at its goal.
  a_sync_result: assert property (@(posedge clk) disable iff (rst)
    (accept && (op == OP_SYNC)) |=> (out_valid && done_res && level_written &&
                                     (level == $past(target_level))))
    else $error("sync request gave a wrong result");

  // A ramp step never moves past the goal level.
  a_ramp_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV_WAIT && div_done) |->
      (quotient[LEVEL_W-1:0] <= span) && (quotient[PROD_W-1:LEVEL_W] == '0))
    else $error("ramp quotient exceeds the span");

endmodule

[design/tbf_div.sv]
// Restoring divider that produces one quotient bit per cycle.
module tbf_div
  import tbf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  input  logic [LEN_W-1:0]  divisor,
  output logic              done,
  output logic [PROD_W-1:0] quotient
);

  logic [LEN_W-1:0]  rem;
  logic [CNT_W-1:0]  cnt;
  logic [LEN_W:0]    trial;
  logic [LEN_W+1:0]  diff;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign trial = {rem, quotient[PROD_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(PROD_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient step; the quotient register doubles as the dividend shifter.
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
    end else if (cnt != '0) begin
      if (!diff[LEN_W+1]) begin
        rem      <= diff[LEN_W-1:0];
        quotient <= {quotient[PROD_W-2:0], 1'b1};
      end else begin
        rem      <= trial[LEN_W-1:0];
        quotient <= {quotient[PROD_W-2:0], 1'b0};
      end
    end
  end

endmodule

[sim/fade_checker.sv]
`timescale 1ns / 1ps
// Checker that predicts every brightness fade result and compares it with the block output.
module fade_checker
  import tbf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         op,
  input  logic [LEVEL_W-1:0] target_level,
  input  logic [LEN_W-1:0]   duration_ms,
  input  logic [TIME_W-1:0]  now_ms,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [LEVEL_W-1:0] level,
  input  logic               done_res,
  input  logic               level_written,
  output int                 errors,
  output int                 pending
);

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               done;
    logic               written;
  } fade_result_t;

  // Results still owed by the block, oldest first.
  fade_result_t expected_levels[$];

  // Predicted fade state.
  logic [LEVEL_W-1:0] from_level;
  logic [LEVEL_W-1:0] goal_level;
  logic [LEVEL_W-1:0] cur_level;
  logic [TIME_W-1:0]  fade_start;
  logic [LEN_W-1:0]   fade_len;

  // Linear interpolation between the start and goal levels, truncated toward zero.
  function automatic logic [LEVEL_W-1:0] ramp_level(input logic [TIME_W-1:0] elapsed);
    logic [31:0] span;
    logic [31:0] step;
    if (goal_level >= from_level) begin
      span = goal_level - from_level;
      step = (span * elapsed) / fade_len;
      return from_level + step[LEVEL_W-1:0];
    end else begin
      span = from_level - goal_level;
      step = (span * elapsed) / fade_len;
      return from_level - step[LEVEL_W-1:0];
    end
  endfunction

  // Applies the request on the input ports to the predicted state.
  task automatic apply_request(output fade_result_t res);
    logic               wrote;
    logic [TIME_W-1:0]  elapsed;
    wrote = 1'b0;
    case (op)
      OP_FADE: begin
        if (target_level != goal_level) begin
          from_level = cur_level;
          goal_level = target_level;
          fade_start = now_ms;
          fade_len   = duration_ms;
          if (duration_ms == '0) begin
            cur_level = target_level;
            wrote     = 1'b1;
          end
        end
      end
      OP_TICK: begin
        if (cur_level != goal_level) begin
          elapsed = now_ms - fade_start;
          if (fade_len == '0 || elapsed >= TIME_W'(fade_len)) begin
            cur_level = goal_level;
          end else begin
            cur_level = ramp_level(elapsed);
          end
          wrote = 1'b1;
        end
      end
      OP_SYNC: begin
        from_level = target_level;
        goal_level = target_level;
        cur_level  = target_level;
        wrote      = 1'b1;
      end
      default: begin
      end
    endcase
    res.level   = cur_level;
    res.done    = (cur_level == goal_level);
    res.written = wrote;
  endtask

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  // Scores results first, then predicts the request accepted at the same edge.
  always @(posedge clk) begin : score
    fade_result_t want;
    fade_result_t got;
    if (rst) begin
      from_level = '0;
      goal_level = '0;
      cur_level  = '0;
      fade_start = '0;
      fade_len   = '0;
      errors     = 0;
      expected_levels.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{level, done_res, level_written};
        if (expected_levels.size() == 0) begin
          report_mismatch("result with nothing pending", got.level, -1);
        end else begin
          want = expected_levels.pop_front();
          if (got.level != want.level) report_mismatch("level", got.level, want.level);
          if (got.done != want.done) report_mismatch("done_res", got.done, want.done);
          if (got.written != want.written) begin
            report_mismatch("level_written", got.written, want.written);
          end
        end
      end
      if (in_valid && !in_stall) begin
        apply_request(want);
        expected_levels.push_back(want);
      end
    end
    pending = expected_levels.size();
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// Top of the brightness fade testbench: clock, reset, request stimulus and the verdict.
module testbench
  import tbf_pkg::*;
();

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         QUIET_LIMIT  = 3000;
  localparam int         DRAIN_CYCLES = 40;
  localparam int         PHASE_ITEMS  = 160;

  logic               clk           = 1'b0;
  logic               rst           = 1'b1;
  logic               in_valid      = 1'b0;
  logic               in_stall;
  logic [1:0]         op            = OP_FADE;
  logic [LEVEL_W-1:0] target_level  = '0;
  logic [LEN_W-1:0]   duration_ms   = '0;
  logic [TIME_W-1:0]  now_ms        = '0;
  logic               out_valid;
  logic               out_stall     = 1'b0;
  logic [LEVEL_W-1:0] level;
  logic               done_res;
  logic               level_written;

  int errors;
  int pending;
  int sender_idle_pct = 0;
  int stall_pct       = 0;
  int quiet_cycles    = 0;

  always #4 clk = ~clk;

  timed_brightness_fade dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .target_level (target_level),
    .duration_ms  (duration_ms),
    .now_ms       (now_ms),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .level        (level),
    .done_res     (done_res),
    .level_written(level_written)
  );

  fade_checker fade_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .target_level (target_level),
    .duration_ms  (duration_ms),
    .now_ms       (now_ms),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .level        (level),
    .done_res     (done_res),
    .level_written(level_written),
    .errors       (errors),
    .pending      (pending)
  );

  // The receiver stalls at random according to the current phase.
  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < stall_pct);
  end

  // Watchdog: ends the run if neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one request after a random idle gap and holds it until accepted.
  task automatic send_request(input logic [1:0] code, input logic [LEVEL_W-1:0] tgt,
                              input logic [LEN_W-1:0] dur, input logic [TIME_W-1:0] stamp);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    op           = code;
    target_level = tgt;
    duration_ms  = dur;
    now_ms       = stamp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Stops offering requests until every predicted result has come back.
  task automatic drain_results();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Mostly whole fades with ticks spread across them, plus random noise requests.
  task automatic run_random(input int count);
    int                 sent;
    int                 ticks;
    logic [LEVEL_W-1:0] tgt;
    logic [LEN_W-1:0]   dur;
    logic [TIME_W-1:0]  t0;
    logic [31:0]        gone;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 20) begin
        send_request(2'($urandom_range(3)), LEVEL_W'($urandom), LEN_W'($urandom), $urandom);
        sent++;
      end else begin
        if ($urandom_range(3) == 0) begin
          send_request(OP_SYNC, LEVEL_W'($urandom), LEN_W'($urandom), $urandom);
          sent++;
        end
        tgt = LEVEL_W'($urandom);
        case ($urandom_range(9))
          0:       dur = '0;
          1, 2:    dur = LEN_W'($urandom);
          default: dur = LEN_W'($urandom_range(400, 1));
        endcase
        t0 = $urandom;
        send_request(OP_FADE, tgt, dur, t0);
        sent++;
        gone  = 0;
        ticks = $urandom_range(8, 1);
        repeat (ticks) begin
          if ($urandom_range(9) == 0) begin
            gone = gone + dur + $urandom_range(3);
          end else begin
            gone = gone + $urandom_range(dur / 4 + 1, 0);
          end
          send_request(OP_TICK, LEVEL_W'($urandom), LEN_W'($urandom), t0 + gone);
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: field extremes, the unused code, jumps, wrapping time and special cases.
    send_request(OP_SYNC, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(OP_UNUSED, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(OP_SYNC, 8'h00, 16'h0000, 32'h0000_0000);
    send_request(OP_FADE, 8'h00, 16'h0000, 32'h0000_0000);
    send_request(OP_FADE, 8'hFF, 16'h0000, 32'h0000_0000);
    send_request(OP_TICK, 8'h00, 16'h0000, 32'h0000_0000);
    send_request(OP_FADE, 8'h00, 16'hFFFF, 32'hFFFF_FFF0);
    send_request(OP_TICK, 8'h00, 16'h0000, 32'hFFFF_FFF0);
    send_request(OP_TICK, 8'h00, 16'h0000, 32'h0000_7FF0);
    send_request(OP_TICK, 8'h00, 16'h0000, 32'h0000_FFEE);
    send_request(OP_TICK, 8'h00, 16'h0000, 32'h0000_FFEF);
    send_request(OP_TICK, 8'h00, 16'h0000, 32'h0001_0000);
    send_request(OP_FADE, 8'd200, 16'd1000, 32'd5000);
    send_request(OP_FADE, 8'd200, 16'd7, 32'd9);
    send_request(OP_TICK, 8'h00, 16'h0000, 32'd5999);
    send_request(OP_SYNC, 8'd100, 16'h0000, 32'd0);
    send_request(OP_FADE, 8'd50, 16'd3, 32'd100);
    send_request(OP_TICK, 8'h00, 16'h0000, 32'd101);
    send_request(OP_TICK, 8'h00, 16'h0000, 32'd99);
    send_request(OP_FADE, 8'd60, 16'd1, 32'd0);
    send_request(OP_TICK, 8'h00, 16'h0000, 32'd0);
    send_request(OP_TICK, 8'h00, 16'h0000, 32'd1);

    // Random phases with different idling on each side.
    run_random(PHASE_ITEMS);
    drain_results();

    sender_idle_pct = 80;
    stall_pct       = 0;
    run_random(PHASE_ITEMS);

    sender_idle_pct = 0;
    stall_pct       = 80;
    run_random(PHASE_ITEMS);

    sender_idle_pct = 24;
    stall_pct       = 24;
    run_random(PHASE_ITEMS);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sim.f]
design/tbf_pkg.sv
design/tbf_div.sv
design/timed_brightness_fade.sv
sim/fade_checker.sv
sim/testbench.sv
